@@ hdl/motor_speed_pid_with_direction_infer_defines.svh @@
// Assertion macros for the checker file of the speed controller.
`ifndef MOTOR_SPEED_PID_WITH_DIRECTION_INFER_DEFINES_SVH
`define MOTOR_SPEED_PID_WITH_DIRECTION_INFER_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while reset is asserted.
`define MSPID_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and quiet while reset is asserted.
`define MSPID_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/mspid_pkg.sv @@
// Types and constants shared by the speed controller modules.
package mspid_pkg;

    localparam int EFFORT_W   = 12;
    localparam int SPEED_W    = 13;
    localparam int ERR_W      = 14;
    localparam int DSP_W      = 14;
    localparam int INTEG_W    = 10;
    localparam int INTEG_PRE_W = 15;
    localparam int GAIN_W     = 8;
    localparam int THR_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int ACC_W      = 25;
    localparam int FRAC_BITS  = 6;
    localparam int CNT_EXT_W  = 16;
    localparam int MAC_CNT_W  = 3;

    localparam logic [EFFORT_W-1:0] EFFORT_RESET = 12'd2250;
    localparam logic [EFFORT_W-1:0] EFFORT_MAX   = 12'd3999;
    localparam logic [EFFORT_W-1:0] EFFORT_MIN   = 12'd1;
    localparam logic [EFFORT_W-1:0] WIN_LOW      = 12'd2100;
    localparam logic [EFFORT_W-1:0] WIN_HIGH     = 12'd2500;
    localparam logic [EFFORT_W-1:0] COUNT_SAT    = 12'd4095;

    localparam logic signed [INTEG_PRE_W-1:0] INTEG_HI = 15'sd400;
    localparam logic signed [INTEG_PRE_W-1:0] INTEG_LO = -15'sd400;

    // 9/10 as a 16-bit fraction, rounded up; exact after truncation for |x| <= 400.
    localparam logic [15:0] DECAY_MUL   = 16'd58983;
    localparam int          DECAY_SHIFT = 16;

    localparam logic [GAIN_W-1:0] GAIN_PROP_RESET  = 8'd23;
    localparam logic [GAIN_W-1:0] GAIN_INTEG_RESET = 8'd12;
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RESET = 8'd10;
    localparam logic [THR_W-1:0]  INTEG_THR_RESET  = 13'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP  = 2'd0,
        CFG_GAIN_INTEG = 2'd1,
        CFG_GAIN_DERIV = 2'd2,
        CFG_INTEG_THR  = 2'd3
    } cfg_idx_t;

    // Direction is kept as a sign: -1 reverse, 0 unknown, +1 forward.
    typedef logic signed [1:0] dir_t;
    localparam dir_t DIR_REV  = -2'sd1;
    localparam dir_t DIR_NONE = 2'sd0;
    localparam dir_t DIR_FWD  = 2'sd1;

    typedef struct packed {
        logic load;
    } mac_ctl_t;

    typedef struct packed {
        logic busy;
        logic last;
    } mac_stat_t;

endpackage

@@ hdl/mspid_dir.sv @@
// Direction inference and count signing for one control tick.
module mspid_dir (
    input  logic [mspid_pkg::EFFORT_W-1:0]       effort,
    input  logic [mspid_pkg::EFFORT_W-1:0]       prev_effort,
    input  logic signed [mspid_pkg::SPEED_W-1:0] prev_speed,
    input  logic [mspid_pkg::EFFORT_W-1:0]       count,
    input  mspid_pkg::dir_t                      dir_est,
    input  mspid_pkg::dir_t                      dir_latch,
    output mspid_pkg::dir_t                      dir_est_next,
    output mspid_pkg::dir_t                      dir_latch_next,
    output logic signed [mspid_pkg::SPEED_W-1:0] speed
);
    import mspid_pkg::*;

    logic signed [DSP_W-1:0]    dcount;
    logic signed [EFFORT_W:0]   deffort;
    logic [DSP_W-1:0]           dcount_mag;
    logic [EFFORT_W:0]          deffort_mag;
    dir_t                       quot_dir;
    logic                       negate;
    logic signed [SPEED_W-1:0]  count_s;

    assign dcount  = $signed({2'b00, count}) - $signed({prev_speed[SPEED_W-1], prev_speed});
    assign deffort = $signed({1'b0, effort}) - $signed({1'b0, prev_effort});
    assign dcount_mag  = dcount[DSP_W-1] ? DSP_W'(-dcount) : DSP_W'(dcount);
    assign deffort_mag = deffort[EFFORT_W] ? (EFFORT_W+1)'(-deffort) : (EFFORT_W+1)'(deffort);

    // The truncated quotient is zero when the dividend is the smaller magnitude,
    // otherwise its sign is the product of the operand signs.
    always_comb
    begin
        if (dcount_mag < DSP_W'(deffort_mag))
        begin
            quot_dir = DIR_NONE;
        end
        else if (dcount[DSP_W-1] ^ deffort[EFFORT_W])
        begin
            quot_dir = DIR_REV;
        end
        else
        begin
            quot_dir = DIR_FWD;
        end
    end

    always_comb
    begin
        dir_est_next = dir_est;
        if ((effort > WIN_LOW) && (effort < WIN_HIGH))
        begin
            if (effort != prev_effort)
            begin
                dir_est_next = quot_dir;
            end
        end
        else if (effort <= WIN_LOW)
        begin
            dir_est_next = DIR_REV;
        end
        else
        begin
            dir_est_next = DIR_FWD;
        end
    end

    assign negate = (dir_est_next == DIR_REV) ||
                    ((dir_est_next == DIR_NONE) && (dir_latch == DIR_REV));
    assign dir_latch_next = negate ? DIR_REV : DIR_FWD;
    assign count_s = $signed({1'b0, count});
    assign speed   = negate ? -count_s : count_s;

endmodule

@@ hdl/mspid_mac.sv @@
// Bit-serial multiply-accumulate of the three PID terms, one gain bit per cycle.
module mspid_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mspid_pkg::mac_ctl_t                  ctl,
    output mspid_pkg::mac_stat_t                 stat,
    input  logic [mspid_pkg::GAIN_W-1:0]         gain_p,
    input  logic [mspid_pkg::GAIN_W-1:0]         gain_i,
    input  logic [mspid_pkg::GAIN_W-1:0]         gain_d,
    input  logic [mspid_pkg::EFFORT_W-1:0]       effort,
    input  logic signed [mspid_pkg::ERR_W-1:0]   err,
    input  logic signed [mspid_pkg::INTEG_W-1:0] integ,
    input  logic signed [mspid_pkg::DSP_W-1:0]   dsp,
    output logic signed [mspid_pkg::ACC_W-1:0]   acc
);
    import mspid_pkg::*;

    localparam logic [MAC_CNT_W-1:0] MAC_LAST = MAC_CNT_W'(GAIN_W - 1);

    logic                     busy_reg, busy_next;
    logic [MAC_CNT_W-1:0]     cnt_reg, cnt_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  mp_reg, mp_next;
    logic signed [ACC_W-1:0]  mi_reg, mi_next;
    logic signed [ACC_W-1:0]  md_reg, md_next;
    logic [GAIN_W-1:0]        gp_reg, gp_next;
    logic [GAIN_W-1:0]        gi_reg, gi_next;
    logic [GAIN_W-1:0]        gd_reg, gd_next;
    logic signed [ACC_W-1:0]  part_p, part_i, part_d;

    assign part_p = gp_reg[0] ? mp_reg : '0;
    assign part_i = gi_reg[0] ? mi_reg : '0;
    assign part_d = gd_reg[0] ? md_reg : '0;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mp_next   = mp_reg;
        mi_next   = mi_reg;
        md_next   = md_reg;
        gp_next   = gp_reg;
        gi_next   = gi_reg;
        gd_next   = gd_reg;
        if (ctl.load)
        begin
            // Operands carry the 1/64 scale: error x4, integral x1, speed change x2.
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = $signed(ACC_W'({effort, FRAC_BITS'(0)}));
            mp_next   = ACC_W'(err) <<< 2;
            mi_next   = ACC_W'(integ);
            md_next   = ACC_W'(dsp) <<< 1;
            gp_next   = gain_p;
            gi_next   = gain_i;
            gd_next   = gain_d;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + part_p + part_i + part_d;
            mp_next  = mp_reg <<< 1;
            mi_next  = mi_reg <<< 1;
            md_next  = md_reg <<< 1;
            gp_next  = gp_reg >> 1;
            gi_next  = gi_reg >> 1;
            gd_next  = gd_reg >> 1;
            cnt_next = cnt_reg + MAC_CNT_W'(1);
            if (cnt_reg == MAC_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mp_reg  <= mp_next;
        mi_reg  <= mi_next;
        md_reg  <= md_next;
        gp_reg  <= gp_next;
        gi_reg  <= gi_next;
        gd_reg  <= gd_next;
    end

    assign stat.busy = busy_reg;
    assign stat.last = busy_reg && (cnt_reg == MAC_LAST);
    assign acc       = acc_reg;

endmodule

@@ hdl/motor_speed_pid_with_direction_infer.sv @@
// One transaction is handled at a time; with encoder_ok clear the control update and the
// bit-serial gain multiply-accumulate are skipped. The multiply-accumulate takes one gain
// bit a cycle.
// A finished result waits in the output register while the next item is taken in.
// Reset (rst_n, asynchronous, active low) restores the gains, effort 2250 and clears all
// other controller state; the block is ready as soon as reset is released.
module motor_speed_pid_with_direction_infer #(
    parameter int COUNT_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [COUNT_BITS-1:0]                 pulse_count,
    input  logic signed [mspid_pkg::SPEED_W-1:0]  target_speed,
    input  logic                                  encoder_ok,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [mspid_pkg::EFFORT_W-1:0]        drive_effort,
    output logic signed [mspid_pkg::SPEED_W-1:0]  signed_speed,
    output logic signed [mspid_pkg::ERR_W-1:0]    speed_error,
    output logic                                  reverse_latched,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  mspid_pkg::cfg_idx_t                   cfg_index,
    input  logic [mspid_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import mspid_pkg::*;

    localparam int EQ_W = ACC_W - FRAC_BITS;

    // One-hot sequencer: direction, error, integral and operand load, serial MAC, write-back.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIR  = 6'b000010,
        S_ERR  = 6'b000100,
        S_INT  = 6'b001000,
        S_MAC  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [GAIN_W-1:0] gain_prop_reg, gain_integ_reg, gain_deriv_reg;
    logic [THR_W-1:0]  integ_thr_reg;

    // Controller state that persists across ticks.
    logic [EFFORT_W-1:0]       effort_reg, effort_next;
    logic [EFFORT_W-1:0]       prev_effort_reg, prev_effort_next;
    logic signed [SPEED_W-1:0] prev_speed_reg, prev_speed_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    dir_t                      dir_est_reg, dir_est_next;
    dir_t                      dir_latch_reg, dir_latch_next;

    // Per-transaction working registers.
    logic [EFFORT_W-1:0]       count_reg, count_next;
    logic signed [SPEED_W-1:0] target_reg, target_next;
    logic                      run_reg, run_next;
    logic signed [SPEED_W-1:0] speed_reg, speed_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [DSP_W-1:0]   dsp_reg, dsp_next;

    // Output register, which frees the input side while a result waits.
    logic                      out_valid_reg, out_valid_next;
    logic [EFFORT_W-1:0]       out_effort_reg, out_effort_next;
    logic signed [SPEED_W-1:0] out_speed_reg, out_speed_next;
    logic signed [ERR_W-1:0]   out_err_reg, out_err_next;
    logic                      out_rev_reg, out_rev_next;

    logic [CNT_EXT_W-1:0]      count_ext;
    logic [EFFORT_W-1:0]       count_sat;

    dir_t                      dir_calc;
    dir_t                      latch_calc;
    logic signed [SPEED_W-1:0] speed_calc;

    logic [ERR_W-1:0]              err_mag;
    logic                          integ_grow;
    logic signed [INTEG_PRE_W-1:0] integ_sum;
    logic [INTEG_W-1:0]            integ_mag;
    logic [ACC_W-1:0]              decay_prod;
    logic [INTEG_W-1:0]            decay_mag;
    logic signed [INTEG_W-1:0]     decay_val;
    logic signed [INTEG_PRE_W-1:0] integ_pre;
    logic signed [INTEG_W-1:0]     integ_clamped;

    mac_ctl_t                  mac_ctl;
    mac_stat_t                 mac_stat;
    logic signed [ACC_W-1:0]   mac_acc;
    logic [EQ_W-1:0]           effort_quot;
    logic [EFFORT_W-1:0]       effort_calc;
    logic                      out_free;

    // The count is taken to a fixed width so that saturation works for any COUNT_BITS up to 16.
    assign count_ext = CNT_EXT_W'(pulse_count);
    assign count_sat = (count_ext > CNT_EXT_W'(COUNT_SAT)) ? COUNT_SAT : count_ext[EFFORT_W-1:0];

    mspid_dir u_dir (
        .effort         (effort_reg),
        .prev_effort    (prev_effort_reg),
        .prev_speed     (prev_speed_reg),
        .count          (count_reg),
        .dir_est        (dir_est_reg),
        .dir_latch      (dir_latch_reg),
        .dir_est_next   (dir_calc),
        .dir_latch_next (latch_calc),
        .speed          (speed_calc)
    );

    // Integral update: accumulate the error when it is large, otherwise decay it
    // to 9/10 truncated toward zero, then clamp to the integral window.
    assign err_mag    = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
    assign integ_grow = err_mag > ERR_W'(integ_thr_reg);
    assign integ_sum  = INTEG_PRE_W'(integ_reg) + INTEG_PRE_W'(err_reg);
    assign integ_mag  = integ_reg[INTEG_W-1] ? INTEG_W'(-integ_reg) : INTEG_W'(integ_reg);
    assign decay_prod = ACC_W'(integ_mag) * ACC_W'(DECAY_MUL);
    assign decay_mag  = INTEG_W'(decay_prod[ACC_W-1:DECAY_SHIFT]);
    assign decay_val  = integ_reg[INTEG_W-1] ? -$signed(decay_mag) : $signed(decay_mag);
    assign integ_pre  = integ_grow ? integ_sum : INTEG_PRE_W'(decay_val);

    always_comb
    begin
        if (integ_pre > INTEG_HI)
        begin
            integ_clamped = INTEG_W'(INTEG_HI);
        end
        else if (integ_pre < INTEG_LO)
        begin
            integ_clamped = INTEG_W'(INTEG_LO);
        end
        else
        begin
            integ_clamped = integ_pre[INTEG_W-1:0];
        end
    end

    // The MAC starts from 64 times the effort and adds the three gain products.
    mspid_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .stat   (mac_stat),
        .gain_p (gain_prop_reg),
        .gain_i (gain_integ_reg),
        .gain_d (gain_deriv_reg),
        .effort (effort_reg),
        .err    (err_reg),
        .integ  (integ_clamped),
        .dsp    (dsp_reg),
        .acc    (mac_acc)
    );

    // A sum below one whole unit gives the minimum effort; otherwise the sum is
    // positive, so dropping the fraction bits truncates toward zero.
    assign effort_quot = mac_acc[ACC_W-1:FRAC_BITS];
    always_comb
    begin
        if (mac_acc < $signed(ACC_W'(64)))
        begin
            effort_calc = EFFORT_MIN;
        end
        else if (effort_quot > EQ_W'(EFFORT_MAX))
        begin
            effort_calc = EFFORT_MAX;
        end
        else
        begin
            effort_calc = effort_quot[EFFORT_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next       = state_reg;
        effort_next      = effort_reg;
        prev_effort_next = prev_effort_reg;
        prev_speed_next  = prev_speed_reg;
        integ_next       = integ_reg;
        dir_est_next     = dir_est_reg;
        dir_latch_next   = dir_latch_reg;
        count_next       = count_reg;
        target_next      = target_reg;
        run_next         = run_reg;
        speed_next       = speed_reg;
        err_next         = err_reg;
        dsp_next         = dsp_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_effort_next  = out_effort_reg;
        out_speed_next   = out_speed_reg;
        out_err_next     = out_err_reg;
        out_rev_next     = out_rev_reg;
        mac_ctl.load     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    count_next  = count_sat;
                    target_next = target_speed;
                    run_next    = encoder_ok;
                    state_next  = S_DIR;
                end
            end
            S_DIR:
            begin
                if (run_reg)
                begin
                    dir_est_next   = dir_calc;
                    dir_latch_next = latch_calc;
                    speed_next     = speed_calc;
                    state_next     = S_ERR;
                end
                else
                begin
                    // No control update: the raw count passes and the error reads zero.
                    speed_next = $signed({1'b0, count_reg});
                    err_next   = '0;
                    state_next = S_FIN;
                end
            end
            S_ERR:
            begin
                err_next   = ERR_W'(target_reg) - ERR_W'(speed_reg);
                dsp_next   = DSP_W'(prev_speed_reg) - DSP_W'(speed_reg);
                state_next = S_INT;
            end
            S_INT:
            begin
                integ_next   = integ_clamped;
                mac_ctl.load = 1'b1;
                state_next   = S_MAC;
            end
            S_MAC:
            begin
                if (mac_stat.last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    if (run_reg)
                    begin
                        effort_next = effort_calc;
                    end
                    prev_effort_next = run_reg ? effort_calc : effort_reg;
                    prev_speed_next  = speed_reg;
                    out_valid_next   = 1'b1;
                    out_effort_next  = run_reg ? effort_calc : effort_reg;
                    out_speed_next   = speed_reg;
                    out_err_next     = err_reg;
                    out_rev_next     = (dir_latch_reg == DIR_REV);
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            gain_prop_reg   <= GAIN_PROP_RESET;
            gain_integ_reg  <= GAIN_INTEG_RESET;
            gain_deriv_reg  <= GAIN_DERIV_RESET;
            integ_thr_reg   <= INTEG_THR_RESET;
            effort_reg      <= EFFORT_RESET;
            prev_effort_reg <= '0;
            prev_speed_reg  <= '0;
            integ_reg       <= '0;
            dir_est_reg     <= DIR_NONE;
            dir_latch_reg   <= DIR_NONE;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            effort_reg      <= effort_next;
            prev_effort_reg <= prev_effort_next;
            prev_speed_reg  <= prev_speed_next;
            integ_reg       <= integ_next;
            dir_est_reg     <= dir_est_next;
            dir_latch_reg   <= dir_latch_next;
            out_valid_reg   <= out_valid_next;
            // The user sends configuration transactions only while idle; no check here.
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_GAIN_PROP:  gain_prop_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_GAIN_INTEG: gain_integ_reg <= cfg_data[GAIN_W-1:0];
                    CFG_GAIN_DERIV: gain_deriv_reg <= cfg_data[GAIN_W-1:0];
                    CFG_INTEG_THR:  integ_thr_reg  <= cfg_data[THR_W-1:0];
                    default:        gain_prop_reg  <= gain_prop_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg      <= count_next;
        target_reg     <= target_next;
        run_reg        <= run_next;
        speed_reg      <= speed_next;
        err_reg        <= err_next;
        dsp_reg        <= dsp_next;
        out_effort_reg <= out_effort_next;
        out_speed_reg  <= out_speed_next;
        out_err_reg    <= out_err_next;
        out_rev_reg    <= out_rev_next;
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign drive_effort    = out_effort_reg;
    assign signed_speed    = out_speed_reg;
    assign speed_error     = out_err_reg;
    assign reverse_latched = out_rev_reg;

endmodule

@@ hdl/mspid_chk.sv @@
// Port-level checker for the speed controller and its bind statement.
`include "motor_speed_pid_with_direction_infer_defines.svh"

module mspid_chk (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [mspid_pkg::EFFORT_W-1:0]       drive_effort,
    input logic signed [mspid_pkg::SPEED_W-1:0] signed_speed,
    input logic                                 reverse_latched
);
    import mspid_pkg::*;

    // A waiting result must not change until it is taken.
    `MSPID_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive_effort) && $stable(signed_speed), "result changed while stalled")

    // The effort of every valid result lands inside the clamp range.
    `MSPID_ASSERT_IMPL(a_effort_range, out_valid, (drive_effort >= EFFORT_MIN) && (drive_effort <= EFFORT_MAX), "drive effort out of range")

    // A negative speed can only come from a reverse direction, which sets the latch.
    `MSPID_ASSERT_IMPL(a_rev_latch, out_valid && signed_speed[SPEED_W-1], reverse_latched, "negative speed without reverse latch")

    // One transaction is processed at a time.
    `MSPID_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input taken while busy")

endmodule

bind motor_speed_pid_with_direction_infer mspid_chk u_mspid_chk (.*);
